@@ hdl/dfq_pkg.sv @@
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared constants, status codes and cell command/status types for the
// duplicate-rejecting fifo queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

  // queue geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // width wide enough for count, capacity and the reported count
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    STS_ENQ   = 3'd0,
    STS_DUP   = 3'd1,
    STS_FULL  = 3'd2,
    STS_DEQ   = 3'd3,
    STS_EMPTY = 3'd4
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic enq;
    logic deq;
  } cell_cmd_t;

  // status gathered from the row of cells
  typedef struct packed {
    logic              match_any;
    logic [DATA_W-1:0] head;
    logic [DEPTH-1:0]  valid;
  } chain_sts_t;

endpackage

@@ hdl/dfq_cell.sv @@
// ----------------------------------------------------------------------------
// dfq_cell
// One queue slot: holds a value and its valid bit, compares against the
// broadcast key, shifts from its right neighbor on dequeue and loads the key
// when it is the first free slot on enqueue.
// ----------------------------------------------------------------------------
module dfq_cell
  import dfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic              prev_valid_i,
  input  logic [DATA_W-1:0] next_value_i,
  input  logic              next_valid_i,
  output logic [DATA_W-1:0] value_o,
  output logic              valid_o,
  output logic              match_o
);

  logic [DATA_W-1:0] value_q, value_d;
  logic              valid_q, valid_d;
  logic              match_q, match_d;
  logic              tail_slot;

  // first free slot is the one whose left neighbor holds data
  assign tail_slot = !valid_q && prev_valid_i;

  // next slot contents
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.deq) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end else if (cmd_i.enq && tail_slot) begin
      value_d = key_i;
      valid_d = 1'b1;
    end
  end

  // registered compare result
  assign match_d = cmd_i.cmp ? (valid_q && (value_q == key_i)) : match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // slot data needs no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

@@ hdl/dfq_chain.sv @@
// ----------------------------------------------------------------------------
// dfq_chain
// Row of DEPTH cells linked to their neighbors; cell zero is the queue head.
// Collects the per-cell match bits, the valid bits and the head value.
// ----------------------------------------------------------------------------
module dfq_chain
  import dfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] key_i,
  output chain_sts_t        sts_o
);

  logic [DATA_W-1:0] value [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  match;

  // cell row with neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_valid;
    logic [DATA_W-1:0] next_value;
    logic              next_valid;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = value[i+1];
      assign next_valid = valid[i+1];
    end

    dfq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .key_i        (key_i),
      .prev_valid_i (prev_valid),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .value_o      (value[i]),
      .valid_o      (valid[i]),
      .match_o      (match[i])
    );
  end

  // status back to the control
  assign sts_o.match_any = |match;
  assign sts_o.head      = value[0];
  assign sts_o.valid     = valid;

endmodule

@@ hdl/dedup_fifo_queue_unit.sv @@
// ----------------------------------------------------------------------------
// dedup_fifo_queue_unit
// Fifo queue that drops values already present. Top level with operation
// sequencing, entry count, capacity register and the result register.
// ----------------------------------------------------------------------------
// A result beat is offered after its operation beat is taken, compared in every
// cell and committed; a stalled result delays the commit.
// One operation at a time: the next is taken only after the capture, compare and
// commit sequence over the cell row; it is taken while a result waits.
// Reset: count and cell valid bits cleared, capacity set to 64; cell values are
// not cleared and no clearing pass runs, so operations are taken right away.
module dedup_fifo_queue_unit
  import dfq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  // operation channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] item_out_o,
  output logic [2:0]               status_o,
  output logic [OUT_CNT_W-1:0]     count_after_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CMP    = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                op_q;
  logic [DATA_W-1:0]   key_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   item_q, item_d;
  status_e             status_q, status_d;
  logic [OUT_CNT_W-1:0] cnt_out_q;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    cap_eff;
  logic                in_take;
  logic                commit;
  logic                is_full;
  cell_cmd_t           cmd;
  chain_sts_t          sts;

  assign in_take = in_valid_i && !in_stall_o;
  assign commit  = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);

  // effective capacity saturates at the queue depth
  assign cap_ext = CMP_W'(cap_q);
  assign cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign is_full = CMP_W'(count_q) >= cap_eff;

  // operation sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_take) state_d = S_CMP;
      S_CMP:    state_d = S_COMMIT;
      S_COMMIT: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // decide the outcome at commit
  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    item_d   = '0;
    status_d = STS_EMPTY;
    cmd.cmp  = (state_q == S_CMP);
    if (op_q == OP_ENQ) begin
      if (sts.match_any) begin
        status_d = STS_DUP;
      end else if (is_full) begin
        status_d = STS_FULL;
      end else begin
        status_d = STS_ENQ;
        cmd.enq  = commit;
        count_d  = count_q + CNT_W'(1);
      end
    end else begin
      if (count_q == '0) begin
        status_d = STS_EMPTY;
      end else begin
        status_d = STS_DEQ;
        item_d   = sts.head;
        cmd.deq  = commit;
        count_d  = count_q - CNT_W'(1);
      end
    end
  end

  assign cnt_ext = CMP_W'(count_d);

  // cell row
  dfq_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .key_i  (key_q),
    .sts_o  (sts)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (commit) count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operation and result payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= opcode_i;
      key_q <= item_value_i;
    end
    if (commit) begin
      item_q    <= item_d;
      status_q  <= status_d;
      cnt_out_q <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_out_o    = item_q;
  assign status_o      = status_q;
  assign count_after_o = cnt_out_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(sts.valid) == int'(count_q))
    else $error("cell valid bits disagree with entry count");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_d == STS_ENQ) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("enqueue did not grow the count");

  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_d == STS_EMPTY) |=> count_q == $past(count_q))
    else $error("empty dequeue changed the count");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_COMMIT)
    else $error("result beat without a commit");

endmodule
